>>> sv/slrm_pkg.sv
// Package: shared types and constants of the sequence loss/reorder monitor.
package slrm_pkg;

    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned WARM_W = 16;
    localparam logic [WARM_W-1:0] WARMUP_RESET = 16'd1000;

    // Frame classes handed from front to back
    localparam logic [1:0] KIND_INORDER  = 2'd0;
    localparam logic [1:0] KIND_GAP      = 2'd1;
    localparam logic [1:0] KIND_REPEAT   = 2'd2;
    localparam logic [1:0] KIND_DISORDER = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  prev;
        logic [TIME_W-1:0] sender;
        logic [TIME_W-1:0] local_t;
    } t_job;

endpackage

>>> sv/slrm_front.sv
// Front: warm-up, seeding, classification against the last sequence number.
module slrm_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [15:0]               i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [31:0]               i_seq,
    input  logic [63:0]               i_sender,
    input  logic [63:0]               i_local,
    output logic                      o_job_valid,
    input  logic                      i_job_ready,
    output slrm_pkg::t_job            o_job
);
    logic [15:0] r_warm_left;
    logic        r_await_seed;
    logic [31:0] r_prev_seq;
    logic [31:0] w_next;
    logic        w_acc;

    assign o_ready = i_job_ready || (r_warm_left != 16'd0) || r_await_seed;
    assign w_acc   = i_valid && o_ready;
    assign w_next  = r_prev_seq + 32'd1;

    assign o_job_valid = i_valid && (r_warm_left == 16'd0) && !r_await_seed;

    always_comb begin
        o_job.seq     = i_seq;
        o_job.prev    = r_prev_seq;
        o_job.sender  = i_sender;
        o_job.local_t = i_local;
        if (i_seq == w_next) begin
            o_job.kind = slrm_pkg::KIND_INORDER;
        end else if (i_seq > r_prev_seq) begin
            o_job.kind = slrm_pkg::KIND_GAP;
        end else if (i_seq == r_prev_seq) begin
            o_job.kind = slrm_pkg::KIND_REPEAT;
        end else begin
            o_job.kind = slrm_pkg::KIND_DISORDER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_left  <= slrm_pkg::WARMUP_RESET;
            r_await_seed <= 1'b1;
            r_prev_seq   <= '0;
        end else if (i_cfg_we) begin
            r_warm_left <= i_cfg_wdata;
        end else if (w_acc) begin
            if (r_warm_left != 16'd0) begin
                r_warm_left <= r_warm_left - 16'd1;
            end else begin
                r_await_seed <= 1'b0;
                r_prev_seq   <= i_seq;
            end
        end
    end
endmodule

>>> sv/slrm_queue.sv
// Queue: small FIFO of classified frames between front and back.
module slrm_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  slrm_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output slrm_pkg::t_job o_job
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    slrm_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != DEPTH[AW:0]);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

>>> sv/slrm_back.sv
// Back: missing-number store walk, counters and result register.
module slrm_back #(
    parameter int unsigned DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  slrm_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_seq,
    output logic [63:0]    o_arrival,
    output logic [63:0]    o_remote,
    output logic [63:0]    o_delay,
    output logic           o_jump,
    output logic [31:0]    o_gap,
    output logic           o_disorder,
    output logic           o_repeat,
    output logic [31:0]    o_loss,
    output logic [31:0]    o_dis_tot,
    output logic [31:0]    o_rep_tot,
    output logic [31:0]    o_frames
);
    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       r_state;
    slrm_pkg::t_job   r_job;
    logic [IW:0]      r_idx;
    logic [31:0]      r_next;
    logic [31:0]      r_loss, r_dis, r_rep, r_frm;
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      r_rdata;
    logic [IW-1:0]    w_ra;
    logic             w_we;
    logic [31:0]      w_gap;
    logic [IW-1:0]    w_i;
    logic             r_ov;
    logic             w_walk_end;

    // Store with registered read; the read address runs one entry ahead of the walk index.
    logic [31:0] r_store [DEPTH];

    assign w_i     = r_idx[IW-1:0];
    assign w_ra    = ((r_state == ST_WALK) && (r_idx != (IW+1)'(DEPTH - 1)))
                     ? w_i + IW'(1) : '0;
    assign o_ready = (r_state == ST_IDLE) && (!r_ov || i_ready);
    assign w_gap   = r_job.seq - r_job.prev - 32'd1;
    assign w_we    = (r_state == ST_WALK) && (r_job.kind == slrm_pkg::KIND_GAP)
                     && !r_vld[w_i] && (r_next != r_job.seq);
    assign w_walk_end = (r_idx == (IW+1)'(DEPTH - 1))
                        || ((r_job.kind == slrm_pkg::KIND_GAP) && (r_next == r_job.seq))
                        || ((r_job.kind == slrm_pkg::KIND_GAP) && w_we
                            && (r_next + 32'd1 == r_job.seq));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_i] <= r_next;
        end
        r_rdata <= r_store[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_vld   <= '0;
            r_loss  <= '0;
            r_dis   <= '0;
            r_rep   <= '0;
            r_frm   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && (!r_ov || i_ready)) begin
                        r_job  <= i_job;
                        r_idx  <= '0;
                        r_next <= i_job.prev + 32'd1;
                        r_frm  <= r_frm + 32'd1;
                        r_ov   <= 1'b0;
                        case (i_job.kind)
                            slrm_pkg::KIND_GAP: begin
                                r_loss  <= r_loss + (i_job.seq - i_job.prev - 32'd1);
                                r_state <= ST_WALK;
                            end
                            slrm_pkg::KIND_REPEAT: begin
                                r_rep   <= r_rep + 32'd1;
                                r_state <= ST_DONE;
                            end
                            slrm_pkg::KIND_DISORDER: begin
                                r_dis   <= r_dis + 32'd1;
                                r_state <= ST_WALK;
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end else if (i_ready) begin
                        r_ov <= 1'b0;
                    end
                end
                ST_WALK: begin
                    if (r_job.kind == slrm_pkg::KIND_GAP) begin
                        if (w_we) begin
                            r_vld[w_i] <= 1'b1;
                            r_next     <= r_next + 32'd1;
                        end
                    end else if (r_vld[w_i] && (r_rdata == r_job.seq)) begin
                        r_vld[w_i] <= 1'b0;
                        r_loss     <= r_loss - 32'd1;
                    end
                    r_idx <= r_idx + (IW+1)'(1);
                    if (w_walk_end) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_ov    <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result register loaded in the finishing cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            o_seq      <= r_job.seq;
            o_arrival  <= r_job.local_t;
            o_remote   <= r_job.sender;
            o_delay    <= r_job.local_t - r_job.sender;
            o_jump     <= (r_job.local_t < r_job.sender);
            o_gap      <= (r_job.kind == slrm_pkg::KIND_GAP) ? w_gap : 32'd0;
            o_disorder <= (r_job.kind == slrm_pkg::KIND_DISORDER);
            o_repeat   <= (r_job.kind == slrm_pkg::KIND_REPEAT);
            o_loss     <= r_loss;
            o_dis_tot  <= r_dis;
            o_rep_tot  <= r_rep;
            o_frames   <= r_frm;
        end
    end

    assign o_valid = r_ov;
endmodule

>>> sv/sequence_loss_reorder_monitor.sv
// Top level: sequence loss, duplicate and reorder monitor.
//
//  channel   | dir | handshake          | payload
//  s_axis    | in  | tvalid/tready      | tdata: sequence_req, sender_time, local_time
//  m_axis    | out | tvalid/tready      | tdata: result fields (see port)
//  cfg       | in  | i_cfg_we           | warmup_frames
//
// Warm-up and seed frames are taken without waiting for the queue and give no result.
// The back part takes an in-order or repeat frame straight from IDLE to DONE; a gap
// frame walks 1 to MISSING_DEPTH store entries and a disorder frame all of them,
// one per cycle, before it reaches DONE.
// Reset is synchronous, active low; it clears all valid bits at once.
// A result waits in the output register; the back part takes the next frame
// as the result is taken, and the queue lets the front classify meanwhile.
module sequence_loss_reorder_monitor #(
    parameter int unsigned MISSING_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sequence_req[31:0], sender_time[95:32], local_time[159:96]
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // seq_out[31:0], arrival_time[95:32], remote_time[159:96], delay[223:160],
    // jump flag[224], gap_lost[256:225], is_disorder[257], is_repeat[258],
    // loss_total[290:259], disorder_total[322:291], repeat_total[354:323],
    // frames_total[386:355], zero fill to 391
    output logic [391:0] m_axis_tdata
);
    logic           w_fj_v, w_fj_r, w_qb_v, w_qb_r;
    slrm_pkg::t_job w_fj, w_qb;
    logic [31:0] w_seq, w_gap, w_loss, w_dis, w_rep, w_frm;
    logic [63:0] w_arr, w_rem, w_dly;
    logic        w_jump, w_isd, w_isr;

    slrm_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_seq(s_axis_tdata[31:0]), .i_sender(s_axis_tdata[95:32]),
        .i_local(s_axis_tdata[159:96]),
        .o_job_valid(w_fj_v), .i_job_ready(w_fj_r), .o_job(w_fj)
    );

    slrm_queue #(.DEPTH(2)) u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fj_v), .o_ready(w_fj_r), .i_job(w_fj),
        .o_valid(w_qb_v), .i_ready(w_qb_r), .o_job(w_qb)
    );

    slrm_back #(.DEPTH(MISSING_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qb_v), .o_ready(w_qb_r), .i_job(w_qb),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_seq(w_seq), .o_arrival(w_arr), .o_remote(w_rem), .o_delay(w_dly),
        .o_jump(w_jump), .o_gap(w_gap), .o_disorder(w_isd), .o_repeat(w_isr),
        .o_loss(w_loss), .o_dis_tot(w_dis), .o_rep_tot(w_rep), .o_frames(w_frm)
    );

    assign m_axis_tdata = {5'd0, w_frm, w_rep, w_dis, w_loss, w_isr, w_isd, w_gap,
                           w_jump, w_dly, w_rem, w_arr, w_seq};
endmodule

>>> tb/sequence_loss_reorder_monitor_test.sv
// Testbench for the sequence loss, duplicate and reorder monitor.
`timescale 1ns / 1ps

module sequence_loss_reorder_monitor_test;

    localparam int MISS_DEPTH = 64;
    localparam int SETTLE_CYCLES = MISS_DEPTH + 20;

    // Expected result of one counted frame
    typedef struct {
        logic [31:0] seq;
        logic [63:0] arrival;
        logic [63:0] remote;
        logic [63:0] delay;
        logic        jump;
        logic [31:0] gap;
        logic        disorder;
        logic        repeat_flag;
        logic [31:0] loss_tot;
        logic [31:0] disorder_tot;
        logic [31:0] repeat_tot;
        logic [31:0] frames_tot;
    } t_frame_stats;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [15:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // sequence_req, sender_time, local_time (low bits first)
    logic [159:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // seq_out, arrival_time, remote_time, delay, jump flag, gap_lost,
    // is_disorder, is_repeat, loss_total, disorder_total, repeat_total, frames_total
    logic [391:0] m_axis_tdata;

    sequence_loss_reorder_monitor #(.MISSING_DEPTH(MISS_DEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the monitor state
    logic [15:0] warm_left;
    logic        need_seed;
    logic [31:0] prev_num;
    logic [31:0] loss_cnt, disorder_cnt, repeat_cnt, frame_cnt;
    logic [31:0] miss_seq [MISS_DEPTH];
    logic        miss_used [MISS_DEPTH];

    t_frame_stats expected_stats[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic [31:0] seq_cursor = 0;

    task automatic reset_shadow();
        warm_left = slrm_pkg::WARMUP_RESET;
        need_seed = 1'b1;
        prev_num = 0;
        loss_cnt = 0; disorder_cnt = 0; repeat_cnt = 0; frame_cnt = 0;
        for (int i = 0; i < MISS_DEPTH; i++) begin
            miss_used[i] = 1'b0;
            miss_seq[i] = '0;
        end
    endtask

    // Works out the result of one frame, if any, and queues it
    task automatic predict_frame(input logic [31:0] seq, input logic [63:0] snd,
                                 input logic [63:0] loc);
        t_frame_stats r;
        logic [31:0] nxt;
        r.gap = 0; r.disorder = 0; r.repeat_flag = 0;
        if (warm_left != 0) begin
            warm_left = warm_left - 1;
            return;
        end
        if (need_seed) begin
            need_seed = 1'b0;
            prev_num = seq;
            return;
        end
        if (seq != prev_num + 32'd1) begin
            if (seq > prev_num) begin
                r.gap = seq - prev_num - 32'd1;
                loss_cnt += r.gap;
                // lowest missing numbers into free slots, ascending
                nxt = prev_num + 32'd1;
                for (int i = 0; i < MISS_DEPTH && nxt < seq; i++) begin
                    if (!miss_used[i]) begin
                        miss_seq[i] = nxt;
                        miss_used[i] = 1'b1;
                        nxt++;
                    end
                end
            end else if (seq == prev_num) begin
                r.repeat_flag = 1;
                repeat_cnt++;
            end else begin
                r.disorder = 1;
                disorder_cnt++;
                for (int i = 0; i < MISS_DEPTH; i++) begin
                    if (miss_used[i] && miss_seq[i] == seq) begin
                        miss_used[i] = 1'b0;
                        loss_cnt--;
                    end
                end
            end
        end
        prev_num = seq;
        frame_cnt++;
        r.seq = seq; r.arrival = loc; r.remote = snd;
        r.delay = loc - snd;
        r.jump = loc < snd;
        r.loss_tot = loss_cnt; r.disorder_tot = disorder_cnt;
        r.repeat_tot = repeat_cnt; r.frames_tot = frame_cnt;
        expected_stats.insert(expected_stats.size(), r);
    endtask

    // Sends one word, with random idle before it; valid stays up until the
    // next word or until the sender pauses
    task automatic send_frame(input logic [31:0] seq, input logic [63:0] snd,
                              input logic [63:0] loc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {loc, snd, seq};
        predict_frame(seq, snd, loc);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_rand_times(input logic [31:0] seq);
        logic [63:0] snd, loc;
        snd = {$urandom, $urandom};
        case ($urandom_range(3))
            0: loc = snd + $urandom_range(100000);
            1: loc = snd - $urandom_range(100);
            default: loc = {$urandom, $urandom};
        endcase
        send_frame(seq, snd, loc);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_warmup(input logic [15:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        warm_left = value;
    endtask

    // Receiver with random stalls; checks each word against the oldest expectation
    always @(posedge i_clk) begin
        t_frame_stats e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_stats.size() == 0) begin
                $error("unexpected result word %h", m_axis_tdata);
                errors++;
            end else begin
                e = expected_stats.pop_front();
                if (m_axis_tdata[31:0] !== e.seq) begin
                    $error("seq_out exp %h got %h", e.seq, m_axis_tdata[31:0]); errors++;
                end
                if (m_axis_tdata[95:32] !== e.arrival) begin
                    $error("arrival_time exp %h got %h", e.arrival, m_axis_tdata[95:32]);
                    errors++;
                end
                if (m_axis_tdata[159:96] !== e.remote) begin
                    $error("remote_time exp %h got %h", e.remote, m_axis_tdata[159:96]);
                    errors++;
                end
                if (m_axis_tdata[223:160] !== e.delay) begin
                    $error("delay exp %h got %h", e.delay, m_axis_tdata[223:160]); errors++;
                end
                if (m_axis_tdata[224] !== e.jump) begin
                    $error("jump_flag exp %b got %b", e.jump, m_axis_tdata[224]); errors++;
                end
                if (m_axis_tdata[256:225] !== e.gap) begin
                    $error("gap_lost exp %h got %h", e.gap, m_axis_tdata[256:225]); errors++;
                end
                if (m_axis_tdata[257] !== e.disorder) begin
                    $error("is_disorder exp %b got %b", e.disorder, m_axis_tdata[257]);
                    errors++;
                end
                if (m_axis_tdata[258] !== e.repeat_flag) begin
                    $error("is_repeat exp %b got %b", e.repeat_flag, m_axis_tdata[258]);
                    errors++;
                end
                if (m_axis_tdata[290:259] !== e.loss_tot) begin
                    $error("loss_total exp %h got %h", e.loss_tot, m_axis_tdata[290:259]);
                    errors++;
                end
                if (m_axis_tdata[322:291] !== e.disorder_tot) begin
                    $error("disorder_total exp %h got %h", e.disorder_tot,
                           m_axis_tdata[322:291]);
                    errors++;
                end
                if (m_axis_tdata[354:323] !== e.repeat_tot) begin
                    $error("repeat_total exp %h got %h", e.repeat_tot, m_axis_tdata[354:323]);
                    errors++;
                end
                if (m_axis_tdata[386:355] !== e.frames_tot) begin
                    $error("frames_total exp %h got %h", e.frames_tot, m_axis_tdata[386:355]);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Frames inside the reset warm-up give no result
    task automatic test_reset_warmup();
        for (int i = 0; i < 20; i++) send_rand_times($urandom);
    endtask

    // Field extremes, wrap of the sequence, gap, repeat, disorder erase
    task automatic test_directed_cases();
        write_warmup(16'd0);
        send_frame(32'hFFFF_FFFE, 64'd5, 64'd3);          // seed
        send_frame(32'hFFFF_FFFF, '1, 64'd0);             // in order, jump
        send_frame(32'd0, 64'd0, '1);                     // wrap is in order
        send_frame(32'd0, 64'h8000_0000_0000_0000, 64'd1); // repeat
        send_frame(32'd5, 64'd1, 64'd2);                  // gap of 4
        send_frame(32'd2, 64'd1, 64'd2);                  // disorder, erases 2
        send_frame(32'd2, 64'd1, 64'd2);                  // repeat
        send_frame(32'd1, 64'd1, 64'd2);                  // disorder, erases 1
        send_frame(32'd200, 64'd9, 64'd9);                // gap overflowing store
        send_frame(32'd100, 64'd9, 64'd9);                // disorder, not stored
        send_frame(32'd7, 64'd9, 64'd9);                  // disorder, stored
        send_frame(32'hFFFF_FFFF, 64'd0, 64'd0);          // huge gap, fills the one free slot
        send_frame(32'hAAAA_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_frame(32'h5555_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        // the sender holds off until every result is back
        wait_drained();
        send_frame(32'h5555_AAAB, 64'd0, 64'd0);
    endtask

    // Short warm-up settings, then mostly near-sequential random runs
    task automatic test_random_stream(input int count, input logic [15:0] warm);
        int r;
        write_warmup(warm);
        seq_cursor = $urandom;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            // 70..77 repeats the previous number
            if (r < 55) seq_cursor = seq_cursor + 1;
            else if (r < 70) seq_cursor = seq_cursor + $urandom_range(2, 12);
            else if (r >= 78 && r < 92) seq_cursor = seq_cursor - $urandom_range(1, 12);
            else if (r >= 92) seq_cursor = $urandom;
            send_rand_times(seq_cursor);
        end
    endtask

    initial begin
        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_warmup();
        test_directed_cases();
        send_idle_pct = 12; recv_idle_pct = 47;
        test_random_stream(280, 16'd3);
        send_idle_pct = 47; recv_idle_pct = 12;
        test_random_stream(280, 16'hFFFF >> 12);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_stream(280, 16'd1);
        write_warmup(16'hFFFF);
        for (int i = 0; i < 5; i++) send_rand_times($urandom);
        wait_drained();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> sim.f
sv/slrm_pkg.sv
sv/slrm_front.sv
sv/slrm_queue.sv
sv/slrm_back.sv
sv/sequence_loss_reorder_monitor.sv
tb/sequence_loss_reorder_monitor_test.sv
